// ----- rtl/core/cppt_pkg.sv -----
// shared types and constants for the convex polygon point test core
// no dependencies
`default_nettype none

package cppt_pkg;

    // dominant normal axis and sign, selects the projected coordinate pair
    typedef enum logic [2:0] {
        AX_POS_X = 3'd0,
        AX_NEG_X = 3'd1,
        AX_POS_Y = 3'd2,
        AX_NEG_Y = 3'd3,
        AX_POS_Z = 3'd4,
        AX_NEG_Z = 3'd5
    } t_axis;

    // action field codes
    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_VERTEX = 1'b1;

    // magnitude of the -0.01 edge tolerance in Q.32
    localparam longint EPS_Q32 = 64'sd42949672;

endpackage

`default_nettype wire

// ----- rtl/core/convex_polygon_point_test_core.sv -----
// convex polygon point test core: edge-side test of a point on a 2-D projection
// depends on cppt_pkg
//
// usage
//   input channel (i_valid / o_stall) takes one word per cycle while o_stall
//   is low. a start word (action = start) brings the plane normal and the test
//   point; vertex words follow, the one with i_last set closes the polygon back
//   to its first vertex. output channel (o_valid / i_stall) gives one word,
//   o_inside_res, per polygon: 1 when the point lies inside every edge within
//   the tolerance. a result passes the input register, projection and
//   differences, products (the edge products of both edges of each word) and result
//   register before it is on o_valid; a new word may enter before earlier
//   words have left the pipeline.
//   each stage loads when it is empty or its successor moves, so words keep
//   entering while a result waits; o_stall rises only when all four stages are
//   full and the receiver stalls.
//   reset (synchronous, i_rst_n low) empties the pipeline and sets the axis to
//   +x, the test point to the origin and the polygon state to empty.
//   the test point and axis are kept after a result, so a new polygon may
//   follow without a start word.
`default_nettype none

module convex_polygon_point_test_core #(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_action,
    input  wire logic signed [15:0] i_normal_x,
    input  wire logic signed [15:0] i_normal_y,
    input  wire logic signed [15:0] i_normal_z,
    input  wire logic signed [31:0] i_coord_x,
    input  wire logic signed [31:0] i_coord_y,
    input  wire logic signed [31:0] i_coord_z,
    input  wire logic        [15:0] i_vertex_index,
    input  wire logic               i_last,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_inside_res
);
    import cppt_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int EXT_W = (CW > 32) ? CW : 32;
    localparam int DW    = CW + 1;
    localparam int PW    = 2 * DW;
    localparam int RW    = PW + 2;

    // ---------------- stage a: input register ----------------
    logic                 r_a_valid;
    logic                 r_a_action;
    logic                 r_a_last;
    logic signed [15:0]   r_a_nx, r_a_ny, r_a_nz;
    logic signed [CW-1:0] r_a_x, r_a_y, r_a_z;
    logic        [15:0]   r_a_id;

    // ---------------- stage b: differences ----------------
    logic                 r_b_valid;
    logic                 r_b_action;
    logic                 r_b_last;
    logic                 r_b_e1, r_b_e2;
    logic signed [DW-1:0] r_b_su1, r_b_sv1, r_b_du1, r_b_dv1;
    logic signed [DW-1:0] r_b_su2, r_b_sv2, r_b_du2, r_b_dv2;

    // ---------------- stage c: products ----------------
    logic                 r_c_valid;
    logic                 r_c_action;
    logic                 r_c_last;
    logic                 r_c_e1, r_c_e2;
    logic signed [PW-1:0] r_c_p1a, r_c_p1b, r_c_p2a, r_c_p2b;

    // ---------------- output register ----------------
    logic r_o_valid;
    logic r_o_inside;

    // ---------------- polygon state ----------------
    t_axis                r_axis;
    logic signed [CW-1:0] r_test_u, r_test_v;
    logic signed [CW-1:0] r_first_u, r_first_v;
    logic signed [CW-1:0] r_prev_u, r_prev_v;
    logic        [15:0]   r_first_id, r_prev_id;
    logic                 r_seen;
    logic                 r_outside;

    // flow control
    logic ready_o, ready_c, ready_b, ready_a;
    logic move_a, move_b, move_c;

    assign ready_o = !r_o_valid || !i_stall;
    assign ready_c = !r_c_valid || ready_o;
    assign ready_b = !r_b_valid || ready_c;
    assign ready_a = !r_a_valid || ready_b;
    assign move_a  = r_a_valid && ready_b;
    assign move_b  = r_b_valid && ready_c;
    assign move_c  = r_c_valid && ready_o;

    assign o_stall      = !ready_a;
    assign o_valid      = r_o_valid;
    assign o_inside_res = r_o_inside;

    // coordinates wrap to the working width, or sign-extend when it is wider
    logic signed [EXT_W-1:0] x_ext, y_ext, z_ext;
    assign x_ext = EXT_W'(i_coord_x);
    assign y_ext = EXT_W'(i_coord_y);
    assign z_ext = EXT_W'(i_coord_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (ready_a) begin
            r_a_valid <= i_valid;
        end
        if (ready_a && i_valid) begin
            r_a_action <= i_action;
            r_a_last   <= i_last;
            r_a_nx     <= i_normal_x;
            r_a_ny     <= i_normal_y;
            r_a_nz     <= i_normal_z;
            r_a_x      <= x_ext[CW-1:0];
            r_a_y      <= y_ext[CW-1:0];
            r_a_z      <= z_ext[CW-1:0];
            r_a_id     <= i_vertex_index;
        end
    end

    // ---------------- axis pick and projection ----------------
    logic [16:0] ax, ay, az;
    t_axis       n_axis;
    t_axis       proj_axis;
    logic signed [CW-1:0] cur_u, cur_v;

    assign ax = r_a_nx[15] ? (17'd0 - {r_a_nx[15], r_a_nx}) : {1'b0, r_a_nx};
    assign ay = r_a_ny[15] ? (17'd0 - {r_a_ny[15], r_a_ny}) : {1'b0, r_a_ny};
    assign az = r_a_nz[15] ? (17'd0 - {r_a_nz[15], r_a_nz}) : {1'b0, r_a_nz};

    // strict compares: ties fall to the later axis, a zero component is negative
    always_comb begin
        if (ax > ay && ax > az) begin
            n_axis = (!r_a_nx[15] && r_a_nx != 16'sd0) ? AX_POS_X : AX_NEG_X;
        end else if (ax <= ay && ay > az) begin
            n_axis = (!r_a_ny[15] && r_a_ny != 16'sd0) ? AX_POS_Y : AX_NEG_Y;
        end else begin
            n_axis = (!r_a_nz[15] && r_a_nz != 16'sd0) ? AX_POS_Z : AX_NEG_Z;
        end
    end

    assign proj_axis = (r_a_action == ACT_START) ? n_axis : r_axis;

    always_comb begin
        case (proj_axis)
            AX_NEG_X: begin cur_u = r_a_z; cur_v = r_a_y; end
            AX_POS_Y: begin cur_u = r_a_z; cur_v = r_a_x; end
            AX_NEG_Y: begin cur_u = r_a_x; cur_v = r_a_z; end
            AX_POS_Z: begin cur_u = r_a_x; cur_v = r_a_y; end
            AX_NEG_Z: begin cur_u = r_a_y; cur_v = r_a_x; end
            default:  begin cur_u = r_a_y; cur_v = r_a_z; end
        endcase
    end

    // first vertex of the polygon as seen after this word
    logic signed [CW-1:0] n_first_u, n_first_v;
    logic        [15:0]   n_first_id;
    logic                 n_e1, n_e2;

    assign n_first_u  = r_seen ? r_first_u  : cur_u;
    assign n_first_v  = r_seen ? r_first_v  : cur_v;
    assign n_first_id = r_seen ? r_first_id : r_a_id;
    assign n_e1 = (r_a_action == ACT_VERTEX) && r_seen && (r_prev_id != r_a_id);
    assign n_e2 = (r_a_action == ACT_VERTEX) && r_a_last && (n_first_id != r_a_id);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_axis     <= AX_POS_X;
            r_test_u   <= '0;
            r_test_v   <= '0;
            r_first_u  <= '0;
            r_first_v  <= '0;
            r_first_id <= '0;
            r_prev_u   <= '0;
            r_prev_v   <= '0;
            r_prev_id  <= '0;
            r_seen     <= 1'b0;
        end else begin
            if (ready_b) begin
                r_b_valid <= r_a_valid;
            end
            if (move_a) begin
                if (r_a_action == ACT_START) begin
                    r_axis   <= n_axis;
                    r_test_u <= cur_u;
                    r_test_v <= cur_v;
                    r_seen   <= 1'b0;
                end else begin
                    r_first_u  <= n_first_u;
                    r_first_v  <= n_first_v;
                    r_first_id <= n_first_id;
                    r_prev_u   <= cur_u;
                    r_prev_v   <= cur_v;
                    r_prev_id  <= r_a_id;
                    r_seen     <= !r_a_last;
                end
            end
        end
        if (move_a) begin
            r_b_action <= r_a_action;
            r_b_last   <= r_a_last;
            r_b_e1     <= n_e1;
            r_b_e2     <= n_e2;
            // edge prev -> current
            r_b_su1 <= DW'(cur_u) - DW'(r_prev_u);
            r_b_sv1 <= DW'(cur_v) - DW'(r_prev_v);
            r_b_du1 <= DW'(r_prev_u) - DW'(r_test_u);
            r_b_dv1 <= DW'(r_prev_v) - DW'(r_test_v);
            // closing edge current -> first
            r_b_su2 <= DW'(n_first_u) - DW'(cur_u);
            r_b_sv2 <= DW'(n_first_v) - DW'(cur_v);
            r_b_du2 <= DW'(cur_u) - DW'(r_test_u);
            r_b_dv2 <= DW'(cur_v) - DW'(r_test_v);
        end
    end

    // ---------------- products ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (ready_c) begin
            r_c_valid <= r_b_valid;
        end
        if (move_b) begin
            r_c_action <= r_b_action;
            r_c_last   <= r_b_last;
            r_c_e1     <= r_b_e1;
            r_c_e2     <= r_b_e2;
            r_c_p1a    <= PW'(r_b_sv1) * PW'(r_b_du1);
            r_c_p1b    <= PW'(r_b_su1) * PW'(r_b_dv1);
            r_c_p2a    <= PW'(r_b_sv2) * PW'(r_b_du2);
            r_c_p2b    <= PW'(r_b_su2) * PW'(r_b_dv2);
        end
    end

    // ---------------- edge compare and result ----------------
    logic signed [RW-1:0] side1, side2;
    logic                 fail1, fail2;
    logic                 acc_outside;
    logic                 c_result;

    assign side1 = RW'(r_c_p1a) - RW'(r_c_p1b) + RW'(EPS_Q32);
    assign side2 = RW'(r_c_p2a) - RW'(r_c_p2b) + RW'(EPS_Q32);
    assign fail1 = r_c_e1 && side1[RW-1];
    assign fail2 = r_c_e2 && side2[RW-1];
    assign acc_outside = r_outside || fail1 || fail2;
    assign c_result    = (r_c_action == ACT_VERTEX) && r_c_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_outside <= 1'b0;
        end else begin
            if (ready_o) begin
                r_o_valid <= r_c_valid && c_result;
            end
            if (move_c) begin
                if (r_c_action == ACT_START || r_c_last) begin
                    r_outside <= 1'b0;
                end else begin
                    r_outside <= acc_outside;
                end
            end
        end
        if (move_c && c_result) begin
            r_o_inside <= !acc_outside;
        end
    end

    // ---------------- assertions ----------------
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_a_valid && r_b_valid && r_c_valid && r_o_valid))
        else $error("input stalled while a stage is empty");

    a_result_from_closing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ready_o && !(r_c_valid && c_result)) |=> !r_o_valid)
        else $error("result word without a closing vertex");

    a_flag_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move_c && (c_result || r_c_action == ACT_START)) |=> !r_outside)
        else $error("outside flag kept past end of polygon");

    a_seen_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move_a && (r_a_action == ACT_START || r_a_last)) |=> !r_seen)
        else $error("polygon left open after start or closing vertex");

    a_seen_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move_a && r_a_action == ACT_VERTEX && !r_a_last) |=> r_seen)
        else $error("open polygon not marked after a vertex");

endmodule

`default_nettype wire
